/* rtl/core/asd_pkg.sv */
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types, constants and register codes for the audio silence detector.
// ----------------------------------------------------------------------------
`default_nettype none

package asd_pkg;

    // Default sizes of the per-channel filter state and of the energy window
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int WINDOW_DEPTH_DEF = 4096;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int Y_W        = 18;
    localparam int SQ_W       = 36;
    localparam int SUM_W      = 48;
    localparam int HOLD_W     = 32;
    localparam int FRAME_W    = 40;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t REG_NUM_CHANNELS     = cfg_idx_t'(0);
    localparam cfg_idx_t REG_HPF_COEFF        = cfg_idx_t'(1);
    localparam cfg_idx_t REG_WINDOW_LENGTH    = cfg_idx_t'(2);
    localparam cfg_idx_t REG_ENERGY_THRESHOLD = cfg_idx_t'(3);
    localparam cfg_idx_t REG_HOLDOFF_FRAMES   = cfg_idx_t'(4);
    localparam cfg_idx_t REG_INCLUDE_INITIAL  = cfg_idx_t'(5);
    localparam cfg_idx_t REG_BOUNDS_ONLY      = cfg_idx_t'(6);

    // Register reset values
    localparam logic [3:0]        RST_NUM_CHANNELS  = 4'd1;
    localparam logic [15:0]       RST_HPF_COEFF     = 16'd32113;
    localparam logic [12:0]       RST_WINDOW_LENGTH = 13'd960;
    localparam logic [SUM_W-1:0]  RST_THRESHOLD     = 48'd1030792;
    localparam logic [HOLD_W-1:0] RST_HOLDOFF       = 32'd24000;
    localparam logic              RST_INCLUDE_INIT  = 1'b0;
    localparam logic              RST_BOUNDS_ONLY   = 1'b0;

    // Event kinds
    localparam logic KIND_OFF = 1'b0;
    localparam logic KIND_ON  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_SAT,
        ST_SQ,
        ST_DELTA,
        ST_SUM,
        ST_CMP,
        ST_HOLD,
        ST_EMIT,
        ST_EOS
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic acc;
        logic mul;
        logic sat;
        logic sq;
        logic delta;
        logic sum;
        logic cmp;
        logic hold;
        logic emit;
        logic eos;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic frame_end;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/core/asd_ctrl.sv */
// ----------------------------------------------------------------------------
// asd_ctrl
// Sequencer that steps one word at a time through the datapath stages.
// ----------------------------------------------------------------------------
`default_nettype none

module asd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_tlast,
    input  wire asd_pkg::stat_t stat,
    output asd_pkg::cmd_t      cmd
);

    asd_pkg::state_t state_reg;
    asd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= asd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            asd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = s_tlast ? asd_pkg::ST_EOS : asd_pkg::ST_ACC;
                end
            end
            asd_pkg::ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = asd_pkg::ST_MUL;
            end
            asd_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = asd_pkg::ST_SAT;
            end
            asd_pkg::ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = asd_pkg::ST_SQ;
            end
            asd_pkg::ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = asd_pkg::ST_DELTA;
            end
            asd_pkg::ST_DELTA: begin
                cmd.delta  = 1'b1;
                state_next = asd_pkg::ST_SUM;
            end
            asd_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = asd_pkg::ST_CMP;
            end
            asd_pkg::ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = stat.frame_end ? asd_pkg::ST_HOLD : asd_pkg::ST_IDLE;
            end
            asd_pkg::ST_HOLD: begin
                cmd.hold   = 1'b1;
                state_next = asd_pkg::ST_EMIT;
            end
            asd_pkg::ST_EMIT: begin
                // hold until the output register can take a new word
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = asd_pkg::ST_IDLE;
                end
            end
            asd_pkg::ST_EOS: begin
                if (!stat.out_busy) begin
                    cmd.eos    = 1'b1;
                    state_next = asd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = asd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/asd_dpath.sv */
// ----------------------------------------------------------------------------
// asd_dpath
// Filter, energy window, frame decision and output register of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

module asd_dpath #(
    parameter int MAX_CHANNELS = asd_pkg::MAX_CHANNELS_DEF,
    parameter int WINDOW_DEPTH = asd_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire asd_pkg::cmd_t                 cmd,
    output asd_pkg::stat_t                     stat,
    input  wire logic                          cfg_valid,
    input  wire asd_pkg::cfg_idx_t             cfg_index,
    input  wire logic [asd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [asd_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic                               m_kind,
    output logic [asd_pkg::FRAME_W-1:0]        m_frame
);

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = 5;
    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = PTR_W + 1;
    localparam int WIN_W  = 17;
    localparam int ACC_W  = 19;
    localparam int PROD_W = 36;
    localparam int RND_W  = PROD_W + 1;
    localparam int SH_W   = RND_W - 15;
    localparam int DLT_W  = asd_pkg::SQ_W + 1;
    localparam int SUM_W  = asd_pkg::SUM_W;
    localparam int HOLD_W = asd_pkg::HOLD_W;
    localparam int FR_W   = asd_pkg::FRAME_W;
    localparam int Y_W    = asd_pkg::Y_W;
    localparam int SQ_W   = asd_pkg::SQ_W;

    localparam logic signed [SH_W-1:0] Y_MAX = SH_W'(131071);
    localparam logic signed [SH_W-1:0] Y_MIN = -SH_W'(131072);
    localparam logic [HOLD_W-1:0]      HOLD_SAT = '1;

    // Configuration registers
    logic [3:0]        num_channels_reg;
    logic [15:0]       hpf_coeff_reg;
    logic [12:0]       window_length_reg;
    logic [SUM_W-1:0]  threshold_reg;
    logic [HOLD_W-1:0] holdoff_reg;
    logic              include_initial_reg;
    logic              bounds_only_reg;

    // Stream state
    logic signed [asd_pkg::SAMPLE_W-1:0] prev_in_reg  [MAX_CHANNELS];
    logic signed [Y_W-1:0]               prev_out_reg [MAX_CHANNELS];
    logic [PTR_W-1:0]  ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              frame_above_reg;
    logic              above_reg;
    logic              diff_reg;
    logic              sound_on_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] countdown_reg;
    logic [FR_W-1:0]   frame_counter_reg;
    logic [FR_W-1:0]   last_off_reg;
    logic              last_off_valid_reg;
    logic              first_on_reg;

    // Per-item pipeline payload
    logic signed [asd_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Y_W-1:0]    y_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic signed [DLT_W-1:0]  dlt_reg;
    logic [SQ_W-1:0]          rd_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [FR_W-1:0]   out_frame_reg;

    logic [SQ_W-1:0] energy_mem [WINDOW_DEPTH];

    // ---------------- combinational datapath ----------------
    logic [CNT_W-1:0]         eff_ch;
    logic [WIN_W-1:0]         eff_win;
    logic [WIN_W-1:0]         ptr_plus;
    logic [PTR_W-1:0]         ptr_next;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [16:0]       coeff_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SH_W-1:0]   shifted;
    logic signed [Y_W-1:0]    y_next;
    logic signed [SQ_W-1:0]   sq_s;
    logic [SQ_W-1:0]          old_entry;
    logic                     above_now;
    logic                     hold_apply;
    logic [FR_W-1:0]          at_frame;
    logic                     ev_valid;
    logic                     ev_kind;
    logic [FR_W-1:0]          ev_frame;
    logic [HOLD_W-1:0]        new_hold;
    logic                     new_incl;
    logic                     reload;

    always_comb begin
        if (num_channels_reg == 4'd0) begin
            eff_ch = CNT_W'(1);
        end else if (CNT_W'(num_channels_reg) > CNT_W'(MAX_CHANNELS)) begin
            eff_ch = CNT_W'(MAX_CHANNELS);
        end else begin
            eff_ch = CNT_W'(num_channels_reg);
        end

        if (window_length_reg == 13'd0) begin
            eff_win = WIN_W'(1);
        end else if (WIN_W'(window_length_reg) > WIN_W'(WINDOW_DEPTH)) begin
            eff_win = WIN_W'(WINDOW_DEPTH);
        end else begin
            eff_win = WIN_W'(window_length_reg);
        end
    end

    assign ptr_plus = WIN_W'(ptr_reg) + WIN_W'(1);
    assign ptr_next = (ptr_plus >= eff_win) ? '0 : PTR_W'(ptr_plus);

    assign acc_next  = ACC_W'(prev_out_reg[ch_reg]) + ACC_W'(x_reg)
                     - ACC_W'(prev_in_reg[ch_reg]);
    assign coeff_s   = $signed({1'b0, hpf_coeff_reg});
    assign prod_next = acc_reg * coeff_s;

    // round half up, then saturate to the filter output range
    assign rnd     = RND_W'(prod_reg) + RND_W'(16384);
    assign shifted = rnd[RND_W-1:15];
    always_comb begin
        if (shifted > Y_MAX) begin
            y_next = Y_W'(Y_MAX);
        end else if (shifted < Y_MIN) begin
            y_next = Y_W'(Y_MIN);
        end else begin
            y_next = Y_W'(shifted);
        end
    end

    assign sq_s = y_reg * y_reg;

    // entries past the fill mark have not been written since the stream began
    assign old_entry = (FILL_W'(ptr_reg) < fill_reg) ? rd_reg : '0;

    assign above_now = frame_above_reg || (sum_reg > threshold_reg);

    assign stat.frame_end = (CNT_W'(ch_reg) + CNT_W'(1)) >= eff_ch;
    assign stat.out_busy  = out_valid_reg && !m_tready;

    assign hold_apply = diff_reg && (hold_reg >= holdoff_reg);
    assign at_frame   = frame_counter_reg + FR_W'(1) - FR_W'(hold_reg);

    always_comb begin
        ev_valid = 1'b0;
        ev_kind  = asd_pkg::KIND_OFF;
        ev_frame = '0;
        if (cmd.eos) begin
            ev_valid = sound_on_reg || first_on_reg;
            ev_frame = (!sound_on_reg && last_off_valid_reg) ? last_off_reg
                                                             : frame_counter_reg;
        end else if (cmd.emit) begin
            if (hold_apply) begin
                ev_valid = !first_on_reg;
                ev_kind  = above_reg ? asd_pkg::KIND_ON : asd_pkg::KIND_OFF;
                ev_frame = at_frame;
            end else if (!diff_reg) begin
                ev_valid = !sound_on_reg && (countdown_reg == HOLD_W'(1));
            end
        end
    end

    assign new_hold = (cfg_index == asd_pkg::REG_HOLDOFF_FRAMES)
                    ? cfg_data[HOLD_W-1:0] : holdoff_reg;
    assign new_incl = (cfg_index == asd_pkg::REG_INCLUDE_INITIAL)
                    ? cfg_data[0] : include_initial_reg;
    assign reload   = cfg_valid
                   && ((cfg_index == asd_pkg::REG_HOLDOFF_FRAMES)
                    || (cfg_index == asd_pkg::REG_INCLUDE_INITIAL))
                   && (frame_counter_reg == '0) && (ch_reg == '0);

    // ---------------- configuration registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_channels_reg    <= asd_pkg::RST_NUM_CHANNELS;
            hpf_coeff_reg       <= asd_pkg::RST_HPF_COEFF;
            window_length_reg   <= asd_pkg::RST_WINDOW_LENGTH;
            threshold_reg       <= asd_pkg::RST_THRESHOLD;
            holdoff_reg         <= asd_pkg::RST_HOLDOFF;
            include_initial_reg <= asd_pkg::RST_INCLUDE_INIT;
            bounds_only_reg     <= asd_pkg::RST_BOUNDS_ONLY;
        end else if (cfg_valid) begin
            case (cfg_index)
                asd_pkg::REG_NUM_CHANNELS:     num_channels_reg    <= cfg_data[3:0];
                asd_pkg::REG_HPF_COEFF:        hpf_coeff_reg       <= cfg_data[15:0];
                asd_pkg::REG_WINDOW_LENGTH:    window_length_reg   <= cfg_data[12:0];
                asd_pkg::REG_ENERGY_THRESHOLD: threshold_reg       <= cfg_data[SUM_W-1:0];
                asd_pkg::REG_HOLDOFF_FRAMES:   holdoff_reg         <= cfg_data[HOLD_W-1:0];
                asd_pkg::REG_INCLUDE_INITIAL:  include_initial_reg <= cfg_data[0];
                asd_pkg::REG_BOUNDS_ONLY:      bounds_only_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- stream state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.eos) begin
            prev_in_reg        <= '{default: '0};
            prev_out_reg       <= '{default: '0};
            ptr_reg            <= '0;
            fill_reg           <= '0;
            sum_reg            <= '0;
            ch_reg             <= '0;
            frame_above_reg    <= 1'b0;
            above_reg          <= 1'b0;
            diff_reg           <= 1'b0;
            sound_on_reg       <= 1'b0;
            hold_reg           <= '0;
            frame_counter_reg  <= '0;
            last_off_reg       <= '0;
            last_off_valid_reg <= 1'b0;
            first_on_reg       <= 1'b0;
            if (!aresetn) begin
                countdown_reg <= asd_pkg::RST_INCLUDE_INIT ? asd_pkg::RST_HOLDOFF : '0;
            end else begin
                countdown_reg <= include_initial_reg ? holdoff_reg : '0;
            end
        end else begin
            if (cmd.sat) begin
                prev_in_reg[ch_reg]  <= x_reg;
                prev_out_reg[ch_reg] <= y_next;
            end
            if (cmd.sum) begin
                sum_reg <= sum_reg + SUM_W'(dlt_reg);
                ptr_reg <= ptr_next;
                if (FILL_W'(ptr_reg) >= fill_reg) begin
                    fill_reg <= FILL_W'(ptr_reg) + FILL_W'(1);
                end
            end
            if (cmd.cmp) begin
                if (stat.frame_end) begin
                    ch_reg          <= '0;
                    above_reg       <= above_now;
                    frame_above_reg <= 1'b0;
                end else begin
                    ch_reg          <= ch_reg + CH_W'(1);
                    frame_above_reg <= above_now;
                end
            end
            if (cmd.hold) begin
                diff_reg <= (sound_on_reg != above_reg);
                if (sound_on_reg != above_reg) begin
                    if (hold_reg != HOLD_SAT) begin
                        hold_reg <= hold_reg + HOLD_W'(1);
                    end
                end else begin
                    hold_reg <= '0;
                end
            end
            if (cmd.emit) begin
                frame_counter_reg <= frame_counter_reg + FR_W'(1);
                if (hold_apply) begin
                    countdown_reg <= '0;
                    sound_on_reg  <= above_reg;
                    if (above_reg) begin
                        last_off_valid_reg <= 1'b0;
                    end else begin
                        last_off_reg       <= at_frame;
                        last_off_valid_reg <= 1'b1;
                    end
                    if (bounds_only_reg && above_reg) begin
                        first_on_reg <= 1'b1;
                    end
                end else if (!diff_reg && !sound_on_reg && countdown_reg != '0) begin
                    countdown_reg <= countdown_reg - HOLD_W'(1);
                end
            end
            if (reload) begin
                countdown_reg <= new_incl ? new_hold : '0;
            end
        end
    end

    // ---------------- per-item payload ----------------
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= $signed(sample);
        end
        if (cmd.acc) begin
            acc_reg <= acc_next;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.sat) begin
            y_reg <= y_next;
        end
        if (cmd.sq) begin
            sq_reg <= $unsigned(sq_s);
        end
        if (cmd.delta) begin
            dlt_reg <= $signed({1'b0, sq_reg}) - $signed({1'b0, old_entry});
        end
    end

    // ---------------- energy window memory ----------------
    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            energy_mem[ptr_reg] <= sq_reg;
        end
        rd_reg <= energy_mem[ptr_reg];
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ev_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_valid) begin
            out_kind_reg  <= ev_kind;
            out_frame_reg <= ev_frame;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_kind   = out_kind_reg;
    assign m_frame  = out_frame_reg;

    // ---------------- assertions ----------------
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit || cmd.eos) |-> !(out_valid_reg && !m_tready))
        else $error("result issued while output register still held a word");

    a_ch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(ch_reg) < CNT_W'(MAX_CHANNELS))
        else $error("channel index beyond channel count");

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eos |=> (frame_counter_reg == '0 && !sound_on_reg && fill_reg == '0))
        else $error("stream state not cleared after end of stream");

    a_change_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && hold_apply) |=> (sound_on_reg == $past(above_reg)))
        else $error("confirmed level change not applied");

endmodule

`default_nettype wire

/* rtl/core/audio_silence_detector.sv */
// ----------------------------------------------------------------------------
// audio_silence_detector
// RMS silence detector with holdoff over an interleaved audio stream.
// ----------------------------------------------------------------------------
// Each input word carries one Q1.15 sample; channels are interleaved in order
// and num_channels samples make one frame. Every sample passes a per-channel
// first-order high-pass filter, its square enters a sliding energy window of
// window_length entries, and after each sample the running sum is compared
// with energy_threshold; a frame is loud if any of its sums exceeds it. A
// sound-on or sound-off change is reported only after it has persisted for
// holdoff_frames frames, tagged with the frame where it started. A word with
// s_tlast set ends the stream: its sample is ignored, any open sound is
// closed with a sound-off word, and all stream state returns to reset
// (registers keep their values). Timing: a sample steps through a sequencer,
// one stage per cycle (filter sum, filter multiply, round and saturate,
// square, window delta, window update, threshold compare), plus the holdoff
// decision and output steps at the end of a frame; no new word is taken
// until the last one is through, and a result still waiting in the output
// register holds every frame-end or end-of-stream word in its last step,
// whether or not that word produces a result, until the receiver takes the
// waiting word. The energy window lives in a single-port RAM with a fill
// mark, so no clearing pass is needed after reset or end of stream.
// Configuration writes are taken in any cycle but are meant for idle times.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_silence_detector #(
    parameter int MAX_CHANNELS = asd_pkg::MAX_CHANNELS_DEF,
    parameter int WINDOW_DEPTH = asd_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,  // [15:0] sample
    input  wire logic                           s_tlast,  // end_of_stream
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [39:0]                         m_tdata,  // [39:0] frame_number
    output logic [0:0]                          m_tuser,  // [0] event_kind
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire asd_pkg::cfg_idx_t              cfg_index,
    input  wire logic [asd_pkg::CFG_DATA_W-1:0] cfg_data
);

    asd_pkg::cmd_t  cmd;
    asd_pkg::stat_t stat;
    logic           kind;

    // Register writes are always accepted.
    assign cfg_ready = 1'b1;

    // Sequencer: accepts a word, then advances it through the datapath stages.
    asd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Filter, energy window, holdoff logic and output register.
    asd_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_kind    (kind),
        .m_frame   (m_tdata)
    );

    assign m_tuser[0] = kind;

endmodule

`default_nettype wire

/* bench/tb_audio_silence_detector.sv */
// ----------------------------------------------------------------------------
// tb_audio_silence_detector
// Self-checking bench for the RMS silence detector with holdoff.
// ----------------------------------------------------------------------------
// A tracker class recomputes the filter, energy window and holdoff decisions
// for every accepted input word and queues the sound-on / sound-off events it
// predicts; every result word is compared with the oldest queued event. A
// short directed run hits the corner settings, then randomized streams of
// loud, quiet and noisy segments run under changing settings, with random
// gaps on both sides and at least one long receiver stall.
// ----------------------------------------------------------------------------

module tb_audio_silence_detector;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 600000; // cycles before the watchdog trips
    localparam int SETTLE_CYCLES = 30;     // margin for the last word to finish
    localparam int LONG_HOLD     = 300;    // receiver stall that fills the block
    localparam int RANDOM_WORDS  = 1300;

    typedef struct packed {
        logic        kind;
        logic [39:0] frame;
    } sound_event_t;

    // ------------------------------------------------------------------------
    // Event tracker: mirrors the detector and holds the events still owed
    // ------------------------------------------------------------------------
    class silence_tracker;
        // register copies
        logic [3:0]  n_chan;
        logic [15:0] coeff;
        logic [12:0] win_len;
        logic [47:0] thresh;
        logic [31:0] holdoff;
        logic        incl_init;
        logic        bounds;
        // stream state
        int          x_last[8];
        int          y_last[8];
        logic [35:0] win_mem[4096];
        int unsigned wr_ptr;
        int unsigned chan;
        logic [47:0] energy;
        bit          frame_loud;
        bit          sound_on;
        bit          first_on_seen;
        bit          last_off_valid;
        logic [31:0] hold_cnt;
        logic [32:0] init_cnt;
        logic [39:0] frames_done;
        logic [39:0] last_off;

        sound_event_t pending_events[$];
        int errors, reported, on_events, off_events, saturations, eos_words, samples;

        function new();
            n_chan    = asd_pkg::RST_NUM_CHANNELS;
            coeff     = asd_pkg::RST_HPF_COEFF;
            win_len   = asd_pkg::RST_WINDOW_LENGTH;
            thresh    = asd_pkg::RST_THRESHOLD;
            holdoff   = asd_pkg::RST_HOLDOFF;
            incl_init = asd_pkg::RST_INCLUDE_INIT;
            bounds    = asd_pkg::RST_BOUNDS_ONLY;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (x_last[i]) begin
                x_last[i] = 0;
                y_last[i] = 0;
            end
            foreach (win_mem[i]) win_mem[i] = '0;
            wr_ptr         = 0;
            chan           = 0;
            energy         = '0;
            frame_loud     = 0;
            sound_on       = 0;
            first_on_seen  = 0;
            last_off_valid = 0;
            hold_cnt       = '0;
            init_cnt       = incl_init ? {1'b0, holdoff} : '0;
            frames_done    = '0;
            last_off       = '0;
        endfunction

        function void set_register(asd_pkg::cfg_idx_t idx, logic [47:0] val);
            case (idx)
                asd_pkg::REG_NUM_CHANNELS:     n_chan    = val[3:0];
                asd_pkg::REG_HPF_COEFF:        coeff     = val[15:0];
                asd_pkg::REG_WINDOW_LENGTH:    win_len   = val[12:0];
                asd_pkg::REG_ENERGY_THRESHOLD: thresh    = val;
                asd_pkg::REG_HOLDOFF_FRAMES:   holdoff   = val[31:0];
                asd_pkg::REG_INCLUDE_INITIAL:  incl_init = val[0];
                asd_pkg::REG_BOUNDS_ONLY:      bounds    = val[0];
                default:                       return;
            endcase
            // the initial-silence countdown reloads only before the first sample
            if ((idx == asd_pkg::REG_HOLDOFF_FRAMES || idx == asd_pkg::REG_INCLUDE_INITIAL) &&
                frames_done == 0 && chan == 0)
                init_cnt = incl_init ? {1'b0, holdoff} : '0;
        endfunction

        function int unsigned chan_count();
            if (n_chan == 0) return 1;
            if (n_chan > 8) return 8;
            return n_chan;
        endfunction

        function int unsigned win_count();
            if (win_len == 0) return 1;
            if (win_len > 4096) return 4096;
            return win_len;
        endfunction

        function void owe_event(logic kind, logic [39:0] frame);
            pending_events.push_back(sound_event_t'{kind: kind, frame: frame});
        endfunction

        function void take_word(logic [15:0] data, logic eos);
            int unsigned ch;
            int unsigned wp;
            longint      acc;
            longint      y;
            logic [35:0] sq;
            bit          loud;
            logic [39:0] at;

            if (eos) begin
                eos_words++;
                if (sound_on)
                    owe_event(asd_pkg::KIND_OFF, frames_done);
                else if (first_on_seen)
                    owe_event(asd_pkg::KIND_OFF, last_off_valid ? last_off : frames_done);
                clear_stream();
                return;
            end
            samples++;

            // high-pass filter, rounded half up, saturated to 18 bits
            ch  = chan % 8;
            acc = longint'(y_last[ch]) + longint'($signed(data)) - longint'(x_last[ch]);
            y   = (acc * longint'(coeff) + 64'sd16384) >>> 15;
            if (y > 131071) begin
                y = 131071;
                saturations++;
            end else if (y < -131072) begin
                y = -131072;
                saturations++;
            end
            x_last[ch] = int'($signed(data));
            y_last[ch] = int'(y);

            // sliding energy window shared by all channels
            wp          = wr_ptr % 4096;
            sq          = 36'(y * y);
            energy      = energy - win_mem[wp] + sq;
            win_mem[wp] = sq;
            wr_ptr      = (wp + 1 >= win_count()) ? 0 : wp + 1;
            if (energy > thresh) frame_loud = 1;

            if (chan + 1 < chan_count()) begin
                chan++;
                return;
            end
            chan       = 0;
            loud       = frame_loud;
            frame_loud = 0;

            // holdoff decision at the end of the frame
            if (sound_on != loud) begin
                if (hold_cnt != 32'hFFFF_FFFF) hold_cnt++;
                if (hold_cnt >= holdoff) begin
                    at       = frames_done + 40'd1 - 40'(hold_cnt);
                    init_cnt = '0;
                    sound_on = loud;
                    if (loud) begin
                        last_off_valid = 0;
                    end else begin
                        last_off       = at;
                        last_off_valid = 1;
                    end
                    if (!first_on_seen)
                        owe_event(loud ? asd_pkg::KIND_ON : asd_pkg::KIND_OFF, at);
                    if (bounds && sound_on) first_on_seen = 1;
                end
            end else begin
                hold_cnt = '0;
                if (init_cnt > 0 && !sound_on) begin
                    init_cnt = init_cnt - 1;
                    if (init_cnt == 0) owe_event(asd_pkg::KIND_OFF, '0);
                end
            end
            frames_done = frames_done + 40'd1;
        endfunction

        function void check_event(logic kind, logic [39:0] frame);
            sound_event_t want;
            if (pending_events.size() == 0) begin
                errors++;
                if (reported < 10)
                    $display("[%0t] unexpected event: kind %0b frame %0d", $realtime, kind, frame);
                reported++;
                return;
            end
            want = pending_events.pop_front();
            if (want.kind !== kind || want.frame !== frame) begin
                errors++;
                if (reported < 10)
                    $display("[%0t] event mismatch: kind %0b/%0b frame %0d/%0d (exp/act)",
                             $realtime, want.kind, kind, want.frame, frame);
                reported++;
            end else if (kind == asd_pkg::KIND_ON) begin
                on_events++;
            end else begin
                off_events++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] sample
    logic        s_tlast  = 1'b0;  // end_of_stream
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [39:0] frame_number
    logic [0:0]  m_tuser;          // [0] event_kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    asd_pkg::cfg_idx_t cfg_index = asd_pkg::REG_NUM_CHANNELS;
    logic [47:0] cfg_data  = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    audio_silence_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    silence_tracker board = new();

    int  cycle_count   = 0;
    int  sent_words    = 0;
    int  settings_runs = 0;
    int  long_holds    = 0;
    int  tx_idle_max   = 11;  // sender gap ceiling, 0 for back-to-back stretches
    int  rx_idle_max   = 11;  // receiver gap ceiling
    bit  long_hold_req = 0;
    bit  held_once     = 0;
    bit  flip          = 0;   // sign toggle for loud segments

    // ------------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge. Check results
    // before noting the input word of the same edge; a result can never be
    // caused by a word accepted in the same cycle.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
            if (m_tvalid && m_tready) board.check_event(m_tuser[0], m_tdata);
            if (s_tvalid && s_tready) board.take_word(s_tdata, s_tlast);
        end
    end

    // Watchdog: count cycles and give up at a generous limit
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("timeout after %0d cycles, %0d events still owed",
                 cycle_count, board.pending_events.size());
        $display("audio_silence_detector verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: draw a gap per word, drop tready for it, then hold tready
    // until a word is taken. A requested long hold stalls the result side
    // while the sender keeps going, so results back up into the input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 0;
                long_holds++;
                gap = LONG_HOLD;
            end else begin
                gap = $urandom_range(0, rx_idle_max);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: called at a falling edge, return at a falling edge without
    // having driven anything there, so the next call owns that edge.
    // ------------------------------------------------------------------------
    task automatic send_word(logic [15:0] data, logic eos);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= eos;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
        sent_words++;
    endtask

    task automatic sender_rest();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    task automatic write_reg(asd_pkg::cfg_idx_t idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
    endtask

    // Write every register in index order; only call while the block is idle
    task automatic apply_settings(logic [3:0] ch, logic [15:0] co, logic [12:0] wl,
                                  logic [47:0] th, logic [31:0] ho, logic ii, logic bo);
        write_reg(asd_pkg::REG_NUM_CHANNELS, 48'(ch));
        write_reg(asd_pkg::REG_HPF_COEFF, 48'(co));
        write_reg(asd_pkg::REG_WINDOW_LENGTH, 48'(wl));
        write_reg(asd_pkg::REG_ENERGY_THRESHOLD, th);
        write_reg(asd_pkg::REG_HOLDOFF_FRAMES, 48'(ho));
        write_reg(asd_pkg::REG_INCLUDE_INITIAL, 48'(ii));
        write_reg(asd_pkg::REG_BOUNDS_ONLY, 48'(bo));
        cfg_valid <= 1'b0;
        settings_runs++;
    endtask

    // Wait until every owed event has arrived, then let the last word finish
    task automatic settle();
        while (board.pending_events.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // One randomized stream: fresh settings, then loud, quiet and noisy
    // segments sized around the holdoff so that changes both pass and fail
    // confirmation. Most streams close with an end-of-stream word.
    // ------------------------------------------------------------------------
    task automatic random_stream();
        logic [3:0]  ch;
        logic [15:0] co;
        logic [12:0] wl;
        logic [47:0] th;
        logic [31:0] ho;
        int          n_eff, w_eff, span, segs, frames, kind, amp, r;
        logic [15:0] smp;
        bit          want_hold;

        want_hold = !held_once || ($urandom_range(0, 5) == 0);

        r  = $urandom_range(0, 9);
        ch = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : (r == 2) ? 4'd8 : 4'($urandom_range(1, 4));
        r  = $urandom_range(0, 9);
        case (r)
            0:       co = 16'd32768;
            1:       co = 16'hFFFF;
            2:       co = 16'd0;
            3:       co = asd_pkg::RST_HPF_COEFF;
            4:       co = 16'($urandom);
            default: co = 16'($urandom_range(8192, 32768));
        endcase
        r  = $urandom_range(0, 11);
        case (r)
            0:       wl = 13'd0;
            1:       wl = 13'd4096;
            2:       wl = 13'd8191;
            3:       wl = 13'($urandom_range(17, 300));
            default: wl = 13'($urandom_range(1, 16));
        endcase
        w_eff = (wl == 0) ? 1 : (wl > 4096) ? 4096 : wl;
        r  = $urandom_range(0, 9);
        case (r)
            0:       th = '0;
            1:       th = 48'hFFFF_FFFF_FFFF;
            default: th = 48'(w_eff) << $urandom_range(8, 26);
        endcase
        r  = $urandom_range(0, 9);
        case (r)
            0:       ho = 32'hFFFF_FFFF;
            1:       ho = asd_pkg::RST_HOLDOFF;
            2:       ho = 32'($urandom_range(5, 12));
            default: ho = 32'($urandom_range(0, 4));
        endcase

        // a stall run needs plenty of results: short holdoff, usable threshold
        if (want_hold) begin
            ho = 32'($urandom_range(0, 1));
            th = 48'(w_eff) << $urandom_range(8, 20);
            held_once = 1;
        end

        apply_settings(ch, co, wl, th, ho, 1'($urandom), 1'($urandom));
        tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
        rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
        if (want_hold) begin
            tx_idle_max   = 0;
            long_hold_req = 1;
        end

        n_eff = (ch == 0) ? 1 : (ch > 8) ? 8 : ch;
        span  = (ho > 6) ? 6 : int'(ho);
        segs  = $urandom_range(2, 8);
        repeat (segs) begin
            kind   = $urandom_range(0, 9);
            frames = $urandom_range(0, span + 3);
            amp    = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(256, 32767);
            if (kind == 9) begin
                // broken frame: a few stray words that shift the frame alignment
                repeat ($urandom_range(1, n_eff)) send_word(16'($urandom), 1'b0);
            end else begin
                repeat (frames * n_eff) begin
                    if (kind <= 4) begin
                        // loud: alternate sign every word, full scale at times
                        if (amp == 32767) smp = flip ? 16'h7FFF : 16'h8000;
                        else              smp = flip ? 16'(amp) : 16'(-amp);
                        flip = !flip;
                    end else if (kind <= 7) begin
                        smp = 16'(int'($urandom_range(0, 15)) - 8);
                    end else begin
                        smp = 16'($urandom);
                    end
                    send_word(smp, 1'b0);
                end
            end
        end
        if ($urandom_range(0, 3) != 0) send_word(16'($urandom), 1'b1);
        sender_rest();
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        // hold reset, then release it on a falling edge
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Initial silence, then a confirmed sound-on and sound-off with holdoff 2
        apply_settings(4'd1, 16'd16384, 13'd1, 48'd1 << 20, 32'd2, 1'b1, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        repeat (6) send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        sender_rest();
        settle();

        // Bounds only, zero holdoff, zero threshold, saturating gain; the
        // end of stream closes the open sound
        apply_settings(4'd2, 16'hFFFF, 13'd4, 48'd0, 32'd0, 1'b0, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h5A5A, 1'b1);
        sender_rest();
        settle();

        // Zero channel count and window, muted filter, top threshold and
        // holdoff: nothing may come out, even at end of stream
        apply_settings(4'd0, 16'd0, 13'd0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b1);
        sender_rest();
        settle();

        // Randomized streams until the word budget is spent
        while (sent_words < RANDOM_WORDS + 25) random_stream();

        settle();
        $display("covered %0d words (%0d samples, %0d stream ends) under %0d settings",
                 sent_words, board.samples, board.eos_words, settings_runs);
        $display("checked %0d on and %0d off events, %0d saturated outputs, %0d long stalls",
                 board.on_events, board.off_events, board.saturations, long_holds);
        if (board.errors == 0 && board.pending_events.size() == 0) begin
            $display("audio_silence_detector verification clean");
        end else begin
            $display("%0d mismatches, %0d events never arrived",
                     board.errors, board.pending_events.size());
            $display("audio_silence_detector verification failed");
        end
        $finish;
    end

endmodule
